### rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round robin time slice scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ID_BITS     = 8;
  localparam int unsigned DEF_TIME_BITS   = 32;

  localparam logic [31:0] SLICE_RESET = 32'd1000;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_DECIDE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    DEC_NONE    = 2'd0,
    DEC_ASSIGN  = 2'd1,
    DEC_PREEMPT = 2'd2
  } decision_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] task_id;
    logic       running_valid;
    logic [7:0] running_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         decision;
    logic [7:0]         assign_id;
    logic [7:0]         resign_id;
    logic               slice_active;
    logic signed [31:0] slice_left;
    logic               queue_full_drop;
    logic [4:0]         queue_count;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/round_robin_timeslice_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_timeslice_scheduler_top
// Round robin time slice scheduler with a compacting ready queue.
// ----------------------------------------------------------------------------
// Each word is handled in two steps: the request is captured, then applied
// to the queue cells and the remaining slice counter, and the result register
// is loaded. The apply step waits while an earlier result has not been taken.
// The remaining slice is kept as one down counter, so slice_left needs no
// subtraction. time_slice may be written at any idle time.
`default_nettype none

module round_robin_timeslice_scheduler_top
  import rrts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = DEF_ID_BITS,
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rrts_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  assign out_valid = status.out_valid;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_drop_no_decision: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.queue_full_drop) |-> (out_data.decision == DEC_NONE))
    else $error("dropped add carries a decision");

  a_preempt_requeued: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.decision == DEC_PREEMPT)) |-> (out_data.queue_count != 5'd0))
    else $error("preempted task not requeued");
`endif

endmodule

`default_nettype wire

### rtl/core/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: captures one word, then applies it once the result slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_e state;
  state_e state_next;
  logic   slot_free;

  assign slot_free = !status.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      ST_EXEC: begin
        cmd.apply = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp
// Datapath: compacting id queue, remaining slice counter, slice register and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dp
  import rrts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = DEF_ID_BITS,
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire in_word_t    in_data,
  output out_word_t        out_data,
  input  wire logic        out_ready,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  logic [ID_BITS-1:0]   q      [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   q_next [QUEUE_DEPTH];
  logic [CW-1:0]        fill;
  logic [CW-1:0]        fill_next;
  logic [TIME_BITS-1:0] left;
  logic [TIME_BITS-1:0] left_next;
  logic [31:0]          time_slice;
  in_word_t             req;
  logic                 out_valid;

  logic [ID_BITS-1:0]     tid;
  logic [ID_BITS-1:0]     rid;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] rm_shift;
  logic                   found;
  logic                   expired;
  logic                   do_add;
  logic                   do_rm;
  logic                   do_pop;
  logic                   do_push;
  logic [CW-1:0]          tail;
  out_word_t              res;

  assign tid     = ID_BITS'(req.task_id);
  assign rid     = ID_BITS'(req.running_id);
  assign expired = (left == '0);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (q[i] == tid) && (CW'(i) < fill);
    end
  end

  // lowest match and every cell above it shift down
  assign rm_shift = match | (~match + 1'b1);
  assign found    = |match;

  assign do_add  = (req_e'(req.req_type) == REQ_ADD) && (fill != FULL);
  assign do_rm   = (req_e'(req.req_type) == REQ_REMOVE) && found;
  assign do_pop  = (req_e'(req.req_type) == REQ_DECIDE) && (fill != '0)
                   && (expired || !req.running_valid);
  assign do_push = do_pop && expired && req.running_valid;
  assign tail    = fill - 1'b1;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] upper;
    if (g < QUEUE_DEPTH - 1) begin : g_up
      assign upper = q[g+1];
    end else begin : g_top
      assign upper = q[g];
    end
    always_comb begin
      q_next[g] = q[g];
      if (do_add && (CW'(g) == fill)) begin
        q_next[g] = tid;
      end else if (do_rm && rm_shift[g]) begin
        q_next[g] = upper;
      end else if (do_pop) begin
        q_next[g] = (do_push && (CW'(g) == tail)) ? rid : upper;
      end
    end
  end

  always_comb begin
    fill_next = fill;
    left_next = left;
    case (req_e'(req.req_type))
      REQ_TICK: begin
        left_next = left - 1'b1;
      end
      REQ_ADD: begin
        if (do_add) begin
          fill_next = fill + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (do_rm) begin
          fill_next = tail;
        end
      end
      REQ_DECIDE: begin
        if (do_pop) begin
          left_next = TIME_BITS'(time_slice);
          if (!do_push) begin
            fill_next = tail;
          end
        end
      end
      default: begin
        fill_next = fill;
      end
    endcase
  end

  always_comb begin
    res.decision        = do_push ? DEC_PREEMPT : (do_pop ? DEC_ASSIGN : DEC_NONE);
    res.assign_id       = do_pop ? 8'(q[0]) : 8'd0;
    res.resign_id       = do_push ? 8'(rid) : 8'd0;
    res.slice_active    = ((fill_next != '0) || req.running_valid) && (left_next != '0)
                          && !left_next[TIME_BITS-1];
    res.slice_left      = 32'(left_next);
    res.queue_full_drop = (req_e'(req.req_type) == REQ_ADD) && (fill == FULL);
    res.queue_count     = 5'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      left       <= '0;
      time_slice <= SLICE_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_slice <= cfg_data;
      end
      if (cmd.apply) begin
        fill      <= fill_next;
        left      <= left_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
    if (cmd.apply) begin
      q        <= q_next;
      out_data <= res;
    end
  end

  assign status.out_valid = out_valid;

endmodule

`default_nettype wire
